>>> hdl/skvt_pkg.sv
// Shared types and operation codes for the sorted key-value table.
`timescale 1ns / 1ps

package skvt_pkg;

    localparam int FIELD_BITS   = 32;
    localparam int ENTRIES_BITS = 5;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_FIND   = 3'd1;
    localparam logic [2:0] OP_ERASE  = 3'd2;
    localparam logic [2:0] OP_ACCESS = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]            op;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] data_in;
    } t_request;

    typedef struct packed {
        logic                    success;
        logic                    found;
        logic [FIELD_BITS-1:0]   data_out;
        logic [ENTRIES_BITS-1:0] entries;
        logic                    full_reject;
    } t_result;

endpackage

>>> hdl/skvt_store.sv
// Key and value memories: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module skvt_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int KEY_W  = 32,
    parameter int VAL_W  = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [KEY_W-1:0]  i_wkey,
    input  logic [VAL_W-1:0]  i_wval,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [KEY_W-1:0]  o_rkey,
    output logic [VAL_W-1:0]  o_rval
);

    logic [KEY_W-1:0] r_key_mem [DEPTH];
    logic [VAL_W-1:0] r_val_mem [DEPTH];
    logic [KEY_W-1:0] r_rkey;
    logic [VAL_W-1:0] r_rval;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key_mem[i_waddr] <= i_wkey;
            r_val_mem[i_waddr] <= i_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rkey <= r_key_mem[i_raddr];
        r_rval <= r_val_mem[i_raddr];
    end

    assign o_rkey = r_rkey;
    assign o_rval = r_rval;

endmodule

>>> hdl/sorted_key_value_table_core.sv
// Top level: sequencer for the sorted key-value table over a shared compare unit.
// Clear and unused codes answer straight from idle; find and erase scan, then decide, and erase
//   may shift left; insert and access scan, then decide, and may shift right before the put.
// Throughput: one item at a time; busy stays high until the result strobe.
// The scan reads one stored entry per cycle; each shift moves one entry per cycle.
// Reset (synchronous, active low) empties the table; memory contents are not cleared.
`timescale 1ns / 1ps

module sorted_key_value_table_core #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  skvt_pkg::t_request i_req,
    output logic              o_valid,
    output skvt_pkg::t_result o_rsp
);

    import skvt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
    localparam int VW = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHL    = 3'd3;
    localparam logic [2:0] S_SHR    = 3'd4;
    localparam logic [2:0] S_PUT    = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_op, n_op;
    logic [KW-1:0] r_key, n_key;
    logic [VW-1:0] r_val, n_val;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_hit, n_hit;
    logic [VW-1:0] r_fval, n_fval;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_valid, n_valid;
    logic          r_success, n_success;
    logic          r_found, n_found;
    logic [VW-1:0] r_data, n_data;
    logic          r_reject, n_reject;

    logic          s_we;
    logic [CW-1:0] s_waddr;
    logic [KW-1:0] s_wkey;
    logic [VW-1:0] s_wval;
    logic [CW-1:0] s_raddr;
    logic [KW-1:0] s_rkey;
    logic [VW-1:0] s_rval;

    logic [KW:0]   s_diff;
    logic          s_lt;
    logic          s_eq;

    skvt_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (AW),
        .KEY_W  (KW),
        .VAL_W  (VW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr[AW-1:0]),
        .i_wkey  (s_wkey),
        .i_wval  (s_wval),
        .i_raddr (s_raddr[AW-1:0]),
        .o_rkey  (s_rkey),
        .o_rval  (s_rval)
    );

    // shared compare unit: one subtract gives both order and equality
    assign s_diff = {1'b0, s_rkey} - {1'b0, r_key};
    assign s_lt   = s_diff[KW];
    assign s_eq   = (s_diff[KW-1:0] == '0);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_val     = r_val;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_hit     = r_hit;
        n_fval    = r_fval;
        n_cnt     = r_cnt;
        n_valid   = 1'b0;
        n_success = r_success;
        n_found   = r_found;
        n_data    = r_data;
        n_reject  = r_reject;
        s_we      = 1'b0;
        s_waddr   = r_idx;
        s_wkey    = s_rkey;
        s_wval    = s_rval;
        s_raddr   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_req.op;
                    n_key = i_req.key[KW-1:0];
                    n_val = i_req.data_in[VW-1:0];
                    n_idx = '0;
                    case (i_req.op) inside
                        OP_CLEAR: begin
                            n_cnt     = '0;
                            n_valid   = 1'b1;
                            n_success = 1'b1;
                            n_found   = 1'b0;
                            n_data    = '0;
                            n_reject  = 1'b0;
                        end
                        OP_INSERT, OP_FIND, OP_ERASE, OP_ACCESS: begin
                            if (r_cnt == '0) begin
                                n_pos   = '0;
                                n_hit   = 1'b0;
                                n_state = S_DECIDE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_valid   = 1'b1;
                            n_success = 1'b0;
                            n_found   = 1'b0;
                            n_data    = '0;
                            n_reject  = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (s_lt) begin
                    if (r_idx + ONE_C == r_cnt) begin
                        n_pos   = r_cnt;
                        n_hit   = 1'b0;
                        n_state = S_DECIDE;
                    end else begin
                        n_idx   = r_idx + ONE_C;
                        s_raddr = r_idx + ONE_C;
                    end
                end else begin
                    n_pos   = r_idx;
                    n_hit   = s_eq;
                    n_fval  = s_rval;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_success = 1'b0;
                n_found   = r_hit;
                n_data    = '0;
                n_reject  = 1'b0;
                n_state   = S_IDLE;
                case (r_op) inside
                    OP_FIND: begin
                        n_valid   = 1'b1;
                        n_success = 1'b1;
                        n_data    = r_hit ? r_fval : '0;
                    end
                    OP_ERASE: begin
                        if (!r_hit) begin
                            n_valid = 1'b1;
                        end else if (r_pos + ONE_C < r_cnt) begin
                            n_idx   = r_pos;
                            s_raddr = r_pos + ONE_C;
                            n_state = S_SHL;
                        end else begin
                            n_cnt     = r_cnt - ONE_C;
                            n_valid   = 1'b1;
                            n_success = 1'b1;
                        end
                    end
                    OP_INSERT, OP_ACCESS: begin
                        if (r_hit) begin
                            n_valid = 1'b1;
                            if (r_op == OP_ACCESS) begin
                                n_success = 1'b1;
                                n_data    = r_fval;
                            end
                        end else if (r_cnt == CAP_C) begin
                            n_valid  = 1'b1;
                            n_reject = 1'b1;
                        end else if (r_cnt > r_pos) begin
                            n_idx   = r_cnt;
                            s_raddr = r_cnt - ONE_C;
                            n_state = S_SHR;
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    default: begin
                        n_valid = 1'b1;
                    end
                endcase
            end
            S_SHL: begin
                s_we = 1'b1;
                if (r_idx + TWO_C < r_cnt) begin
                    n_idx   = r_idx + ONE_C;
                    s_raddr = r_idx + TWO_C;
                end else begin
                    n_cnt     = r_cnt - ONE_C;
                    n_valid   = 1'b1;
                    n_success = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_SHR: begin
                s_we = 1'b1;
                if (r_idx - ONE_C > r_pos) begin
                    n_idx   = r_idx - ONE_C;
                    s_raddr = r_idx - TWO_C;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                s_we      = 1'b1;
                s_waddr   = r_pos;
                s_wkey    = r_key;
                s_wval    = (r_op == OP_INSERT) ? r_val : '0;
                n_cnt     = r_cnt + ONE_C;
                n_valid   = 1'b1;
                n_success = 1'b1;
                n_found   = 1'b0;
                n_data    = '0;
                n_reject  = 1'b0;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_hit     <= n_hit;
        r_fval    <= n_fval;
        r_success <= n_success;
        r_found   <= n_found;
        r_data    <= n_data;
        r_reject  <= n_reject;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_valid             = r_valid;
    assign o_rsp.success       = r_success;
    assign o_rsp.found         = r_found;
    assign o_rsp.data_out      = FIELD_BITS'(r_data);
    assign o_rsp.entries       = ENTRIES_BITS'(32'(r_cnt));
    assign o_rsp.full_reject   = r_reject;

    a_valid_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while sequencer busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_C)
        else $error("entry count above capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.op == OP_CLEAR) |=> (o_valid && r_cnt == '0))
        else $error("clear did not empty the table");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.full_reject) |-> (r_cnt == CAP_C && !o_rsp.success))
        else $error("full reject with room left");

    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |=> (r_cnt == $past(r_cnt) + ONE_C && o_valid))
        else $error("insert did not grow the table");

endmodule
